// ----- rtl/core/epc_pkg.sv -----
package epc_pkg;

    localparam int MID_DEPTH = 16;
    localparam int OUT_DEPTH = 32;
    localparam int MUL_CHUNK = 32;

    typedef struct packed {
        logic touching;
        logic approaching;
        logic degenerate;
        logic bypass;
    } t_flags;

endpackage

// ----- rtl/core/epc_mul.sv -----
module epc_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             i_clk,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int CH  = epc_pkg::MUL_CHUNK;
    localparam int NC  = (AW + CH - 1) / CH;
    localparam int AXW = NC * CH;
    localparam int PW  = AW + BW;

    logic [AXW-1:0]     a_x;
    logic [CH+BW-1:0]   r_pp [NC];
    logic [PW-1:0]      n_p;
    logic [PW-1:0]      r_p;

    assign a_x = AXW'(i_a);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NC; i++) begin
            r_pp[i] <= (CH+BW)'(a_x[i*CH +: CH]) * (CH+BW)'(i_b);
        end
        r_p <= n_p;
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NC; i++) begin
            n_p = n_p + (PW'(r_pp[i]) << (i * CH));
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/epc_fifo.sv -----
module epc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_data,
    input  logic                       i_pop,
    output logic [W-1:0]               o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PTW-1:0] r_wr;
    logic [PTW-1:0] r_rd;
    logic [CNW-1:0] r_count;
    logic [CNW-1:0] n_count;

    assign n_count = r_count + CNW'(i_push) - CNW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// ----- rtl/core/epc_div.sv -----
module epc_div #(
    parameter int NW = 92,
    parameter int DW = 67,
    parameter int QB = 25
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    logic [NW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_ovf [QB+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= ({1'b0, i_num} >= ((NW+1)'(i_den) << QB));
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [NW:0] trial;

        assign trial = {1'b0, r_rem[j]} - ((NW+1)'(r_den[j]) << (QB - 1 - j));

        always_ff @(posedge i_clk) begin
            r_q[j+1]   <= {r_q[j][QB-2:0], ~trial[NW]};
            r_ovf[j+1] <= r_ovf[j];
        end

        if (j < QB - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_rem[j+1] <= trial[NW] ? r_rem[j] : trial[NW-1:0];
                r_den[j+1] <= r_den[j];
            end
        end
    end

    // quotient too large for QB bits: clamp, saturation downstream covers it
    assign o_quo = r_ovf[QB] ? '1 : r_q[QB];

endmodule

// ----- rtl/core/epc_front.sv -----
module epc_front #(
    parameter int CW = 24,
    parameter int MW = 16,
    localparam int NW  = 3 * CW + MW + 4,
    localparam int DNW = 2 * CW + MW + 3,
    localparam int EW  = 4 * NW + DNW + 2 + 4 * CW + $bits(epc_pkg::t_flags)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_first_pos_x,
    input  logic signed [CW-1:0] i_first_pos_y,
    input  logic signed [CW-1:0] i_first_vel_x,
    input  logic signed [CW-1:0] i_first_vel_y,
    input  logic [MW-1:0]        i_first_mass,
    input  logic [CW-2:0]        i_first_radius,
    input  logic signed [CW-1:0] i_second_pos_x,
    input  logic signed [CW-1:0] i_second_pos_y,
    input  logic signed [CW-1:0] i_second_vel_x,
    input  logic signed [CW-1:0] i_second_vel_y,
    input  logic [MW-1:0]        i_second_mass,
    input  logic [CW-2:0]        i_second_radius,
    output logic                 o_valid,
    output logic [EW-1:0]        o_data
);

    localparam int AW  = CW + 1;
    localparam int SW  = CW + 2;
    localparam int DW2 = 2 * CW + 2;
    localparam int DTW = 2 * CW + 3;
    localparam int MSW = MW + 1;
    localparam int KW  = DW2 + MSW;
    localparam int S2W = 2 * SW + 1;

    // stage A: differences and magnitudes
    logic signed [AW-1:0] a_dx, a_dy, a_dvx, a_dvy;
    logic signed [SW-1:0] a_sx, a_sy;
    logic [AW-1:0]        a_dxm, a_dym, a_dvxm, a_dvym;
    logic [SW-1:0]        a_sxm, a_sym;

    assign a_dx  = AW'(i_first_pos_x) - AW'(i_second_pos_x);
    assign a_dy  = AW'(i_first_pos_y) - AW'(i_second_pos_y);
    assign a_dvx = AW'(i_first_vel_x) - AW'(i_second_vel_x);
    assign a_dvy = AW'(i_first_vel_y) - AW'(i_second_vel_y);
    assign a_sx  = SW'(i_second_pos_x) + SW'(i_second_vel_x)
                 - SW'(i_first_pos_x) - SW'(i_first_vel_x);
    assign a_sy  = SW'(i_second_pos_y) + SW'(i_second_vel_y)
                 - SW'(i_first_pos_y) - SW'(i_first_vel_y);

    assign a_dxm  = a_dx[AW-1]  ? $unsigned(-a_dx)  : $unsigned(a_dx);
    assign a_dym  = a_dy[AW-1]  ? $unsigned(-a_dy)  : $unsigned(a_dy);
    assign a_dvxm = a_dvx[AW-1] ? $unsigned(-a_dvx) : $unsigned(a_dvx);
    assign a_dvym = a_dvy[AW-1] ? $unsigned(-a_dvy) : $unsigned(a_dvy);
    assign a_sxm  = a_sx[SW-1]  ? $unsigned(-a_sx)  : $unsigned(a_sx);
    assign a_sym  = a_sy[SW-1]  ? $unsigned(-a_sy)  : $unsigned(a_sy);

    logic [AW-1:0]        r_a_dvxm, r_a_dvym;
    logic [SW-1:0]        r_a_sxm, r_a_sym;
    logic [CW-1:0]        r_a_rs;

    logic                 r_vld  [9];
    logic [4*CW-1:0]      r_vel  [9];
    logic [1:0]           r_dsg  [9];
    logic [2*AW-1:0]      r_mag  [7];
    logic [1:0]           r_dvsg [3];
    logic [3*MSW-1:0]     r_mass [5];
    epc_pkg::t_flags      r_flg  [6];
    logic                 r_sd   [5];
    logic [DNW-1:0]       r_den_d [2];

    always_ff @(posedge i_clk) begin
        r_a_dvxm  <= a_dvxm;
        r_a_dvym  <= a_dvym;
        r_a_sxm   <= a_sxm;
        r_a_sym   <= a_sym;
        r_a_rs    <= CW'(i_first_radius) + CW'(i_second_radius);
        r_vel[0]  <= {i_first_vel_x, i_first_vel_y, i_second_vel_x, i_second_vel_y};
        r_dsg[0]  <= {a_dx[AW-1], a_dy[AW-1]};
        r_mag[0]  <= {a_dxm, a_dym};
        r_dvsg[0] <= {a_dx[AW-1] ^ a_dvx[AW-1], a_dy[AW-1] ^ a_dvy[AW-1]};
        r_mass[0] <= {MSW'(i_first_mass) + MSW'(i_second_mass),
                      {i_first_mass, 1'b0}, {i_second_mass, 1'b0}};
        for (int i = 1; i < 9; i++) begin
            r_vel[i] <= r_vel[i-1];
            r_dsg[i] <= r_dsg[i-1];
        end
        for (int i = 1; i < 7; i++) begin
            r_mag[i] <= r_mag[i-1];
        end
        for (int i = 1; i < 3; i++) begin
            r_dvsg[i] <= r_dvsg[i-1];
        end
        for (int i = 1; i < 5; i++) begin
            r_mass[i] <= r_mass[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < 9; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // stages B, C: squares and dot terms
    logic [2*AW-1:0] c_dx2, c_dy2, c_pdx, c_pdy;
    logic [2*SW-1:0] c_sx2, c_sy2;
    logic [2*CW-1:0] c_rs2;

    epc_mul #(.AW(AW), .BW(AW)) u_mul_dx2 (
        .i_clk(i_clk), .i_a(r_mag[0][2*AW-1:AW]), .i_b(r_mag[0][2*AW-1:AW]), .o_p(c_dx2));
    epc_mul #(.AW(AW), .BW(AW)) u_mul_dy2 (
        .i_clk(i_clk), .i_a(r_mag[0][AW-1:0]), .i_b(r_mag[0][AW-1:0]), .o_p(c_dy2));
    epc_mul #(.AW(SW), .BW(SW)) u_mul_sx2 (
        .i_clk(i_clk), .i_a(r_a_sxm), .i_b(r_a_sxm), .o_p(c_sx2));
    epc_mul #(.AW(SW), .BW(SW)) u_mul_sy2 (
        .i_clk(i_clk), .i_a(r_a_sym), .i_b(r_a_sym), .o_p(c_sy2));
    epc_mul #(.AW(CW), .BW(CW)) u_mul_rs2 (
        .i_clk(i_clk), .i_a(r_a_rs), .i_b(r_a_rs), .o_p(c_rs2));
    epc_mul #(.AW(AW), .BW(AW)) u_mul_pdx (
        .i_clk(i_clk), .i_a(r_a_dvxm), .i_b(r_mag[0][2*AW-1:AW]), .o_p(c_pdx));
    epc_mul #(.AW(AW), .BW(AW)) u_mul_pdy (
        .i_clk(i_clk), .i_a(r_a_dvym), .i_b(r_mag[0][AW-1:0]), .o_p(c_pdy));

    // stage D: sums and flags
    logic [DW2-1:0]        d_d2;
    logic [S2W-1:0]        d_s2;
    logic signed [DTW-1:0] d_tx, d_ty;
    logic                  d_deg;
    logic [DW2-1:0]        r_d_d2;
    logic signed [DTW-1:0] r_d_dot;

    assign d_d2  = DW2'(c_dx2) + DW2'(c_dy2);
    assign d_s2  = S2W'(c_sx2) + S2W'(c_sy2);
    assign d_tx  = r_dvsg[2][1] ? -$signed(DTW'(c_pdx)) : $signed(DTW'(c_pdx));
    assign d_ty  = r_dvsg[2][0] ? -$signed(DTW'(c_pdy)) : $signed(DTW'(c_pdy));
    assign d_deg = (d_d2 == '0);

    always_ff @(posedge i_clk) begin
        r_d_d2               <= d_d2;
        r_d_dot              <= d_tx + d_ty;
        r_flg[0].touching    <= (S2W'(d_d2) <= S2W'(c_rs2));
        r_flg[0].approaching <= (d_s2 < S2W'(d_d2));
        r_flg[0].degenerate  <= d_deg;
        r_flg[0].bypass      <= d_deg || (r_mass[2][3*MSW-1:2*MSW] == '0);
        for (int i = 1; i < 6; i++) begin
            r_flg[i] <= r_flg[i-1];
        end
    end

    // stage E: dot magnitude
    logic [DW2-1:0] r_e_d2;
    logic [DW2-1:0] r_e_dotm;

    always_ff @(posedge i_clk) begin
        r_e_d2   <= r_d_d2;
        r_sd[0]  <= r_d_dot[DTW-1];
        r_e_dotm <= r_d_dot[DTW-1] ? DW2'($unsigned(-r_d_dot)) : DW2'($unsigned(r_d_dot));
        for (int i = 1; i < 5; i++) begin
            r_sd[i] <= r_sd[i-1];
        end
    end

    // stages F, G: denominator and scale factors
    logic [DNW-1:0] g_den;
    logic [KW-1:0]  g_k1, g_k2;

    epc_mul #(.AW(DW2), .BW(MSW)) u_mul_den (
        .i_clk(i_clk), .i_a(r_e_d2), .i_b(r_mass[4][3*MSW-1:2*MSW]), .o_p(g_den));
    epc_mul #(.AW(DW2), .BW(MSW)) u_mul_k1 (
        .i_clk(i_clk), .i_a(r_e_dotm), .i_b(r_mass[4][MSW-1:0]), .o_p(g_k1));
    epc_mul #(.AW(DW2), .BW(MSW)) u_mul_k2 (
        .i_clk(i_clk), .i_a(r_e_dotm), .i_b(r_mass[4][2*MSW-1:MSW]), .o_p(g_k2));

    // stages H, I: numerators
    logic [NW-1:0] i_n1x, i_n1y, i_n2x, i_n2y;

    epc_mul #(.AW(KW), .BW(AW)) u_mul_n1x (
        .i_clk(i_clk), .i_a(g_k1), .i_b(r_mag[6][2*AW-1:AW]), .o_p(i_n1x));
    epc_mul #(.AW(KW), .BW(AW)) u_mul_n1y (
        .i_clk(i_clk), .i_a(g_k1), .i_b(r_mag[6][AW-1:0]), .o_p(i_n1y));
    epc_mul #(.AW(KW), .BW(AW)) u_mul_n2x (
        .i_clk(i_clk), .i_a(g_k2), .i_b(r_mag[6][2*AW-1:AW]), .o_p(i_n2x));
    epc_mul #(.AW(KW), .BW(AW)) u_mul_n2y (
        .i_clk(i_clk), .i_a(g_k2), .i_b(r_mag[6][AW-1:0]), .o_p(i_n2y));

    always_ff @(posedge i_clk) begin
        r_den_d[0] <= g_den;
        r_den_d[1] <= r_den_d[0];
    end

    assign o_valid = r_vld[8];
    assign o_data  = {i_n1x, i_n1y, i_n2x, i_n2y, r_den_d[1],
                      r_sd[4] ^ r_dsg[8][1], r_sd[4] ^ r_dsg[8][0],
                      r_vel[8], r_flg[5]};

endmodule

// ----- rtl/core/epc_back.sv -----
module epc_back #(
    parameter int CW = 24,
    parameter int MW = 16,
    localparam int NW  = 3 * CW + MW + 4,
    localparam int DNW = 2 * CW + MW + 3,
    localparam int EW  = 4 * NW + DNW + 2 + 4 * CW + $bits(epc_pkg::t_flags),
    localparam int OW  = 4 * CW + 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [EW-1:0] i_data,
    output logic          o_valid,
    output logic [OW-1:0] o_data
);

    localparam int QB = CW + 1;
    localparam logic signed [CW+2:0] MAXV = {4'b0000, {(CW-1){1'b1}}};
    localparam logic signed [CW+2:0] MINV = {4'b1111, {(CW-1){1'b0}}};

    logic [NW-1:0]    u_num [4];
    logic [DNW-1:0]   u_den;
    logic [1:0]       u_sg;
    logic [4*CW-1:0]  u_vel;
    epc_pkg::t_flags  u_flg;

    assign {u_num[0], u_num[1], u_num[2], u_num[3], u_den, u_sg, u_vel, u_flg} = i_data;

    logic             r_vld [QB+1];
    logic [4*CW-1:0]  r_vel [QB+1];
    logic [1:0]       r_sg  [QB+1];
    epc_pkg::t_flags  r_flg [QB+1];

    always_ff @(posedge i_clk) begin
        r_vel[0] <= u_vel;
        r_sg[0]  <= u_sg;
        r_flg[0] <= u_flg;
        for (int i = 1; i <= QB; i++) begin
            r_vel[i] <= r_vel[i-1];
            r_sg[i]  <= r_sg[i-1];
            r_flg[i] <= r_flg[i-1];
        end
    end

    logic          r_out_vld;
    logic [OW-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QB; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int i = 1; i <= QB; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_out_vld <= r_vld[QB];
        end
    end

    logic [CW-1:0] res [4];

    // lanes: first x, first y (subtract), second x, second y (add)
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [QB-1:0]        quo;
        logic signed [CW-1:0] v;
        logic signed [CW+1:0] qs;
        logic signed [CW+2:0] sum;

        epc_div #(.NW(NW), .DW(DNW), .QB(QB)) u_div (
            .i_clk (i_clk),
            .i_num (u_num[l]),
            .i_den (u_den),
            .o_quo (quo)
        );

        assign v   = r_vel[QB][(3-l)*CW +: CW];
        assign qs  = r_sg[QB][1 - (l % 2)] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        assign sum = (l < 2) ? (CW+3)'(v) - (CW+3)'(qs) : (CW+3)'(v) + (CW+3)'(qs);

        assign res[l] = r_flg[QB].bypass ? v :
                        (sum > MAXV) ? MAXV[CW-1:0] :
                        (sum < MINV) ? MINV[CW-1:0] : sum[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_out <= {res[0], res[1], res[2], res[3], r_flg[QB].touching,
                  r_flg[QB].approaching, r_flg[QB].degenerate};
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ----- rtl/core/elastic_pair_collision_unit.sv -----
// channel   direction  handshake               payload
// request   in         push / full             two discs: position, velocity, mass, radius
// result    out        empty / pop             new velocities, touching, approaching, degenerate
//
// One request per cycle sustained while back credit is available. Requests pass the front
// multiply pipeline, the middle queue, the back divider pipeline (one quotient bit per
// stage) and the result queue, in that order.
// Back issue is credit based on a 32-entry result queue: issue pauses once results in
// flight through the back pipeline plus results held in the result queue reach 32.
// Synchronous active-low reset clears valids, counters and queue pointers only.
// A stalled result side fills the result queue, then the middle queue, then raises full.
module elastic_pair_collision_unit #(
    parameter int COORD_WIDTH = 24,
    parameter int MASS_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_first_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_vel_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_vel_y,
    input  logic [MASS_WIDTH-1:0]         i_first_mass,
    input  logic [COORD_WIDTH-2:0]        i_first_radius,
    input  logic signed [COORD_WIDTH-1:0] i_second_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_vel_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_vel_y,
    input  logic [MASS_WIDTH-1:0]         i_second_mass,
    input  logic [COORD_WIDTH-2:0]        i_second_radius,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_WIDTH-1:0] o_new_first_vel_x,
    output logic signed [COORD_WIDTH-1:0] o_new_first_vel_y,
    output logic signed [COORD_WIDTH-1:0] o_new_second_vel_x,
    output logic signed [COORD_WIDTH-1:0] o_new_second_vel_y,
    output logic                          o_touching,
    output logic                          o_approaching,
    output logic                          o_degenerate
);

    localparam int CW  = COORD_WIDTH;
    localparam int MW  = MASS_WIDTH;
    localparam int NW  = 3 * CW + MW + 4;
    localparam int DNW = 2 * CW + MW + 3;
    localparam int EW  = 4 * NW + DNW + 2 + 4 * CW + $bits(epc_pkg::t_flags);
    localparam int OW  = 4 * CW + 3;
    localparam int MQD = epc_pkg::MID_DEPTH;
    localparam int OQD = epc_pkg::OUT_DEPTH;
    localparam int FCW = $clog2(MQD + 1);
    localparam int BCW = $clog2(OQD + 1);

    logic           accept;
    logic           f_valid;
    logic [EW-1:0]  f_data;
    logic [EW-1:0]  mq_data;
    logic [FCW-1:0] mq_count;
    logic           issue;
    logic           b_valid;
    logic [OW-1:0]  b_data;
    logic [OW-1:0]  oq_data;
    logic [BCW-1:0] oq_count;
    logic           oq_pop;
    logic [FCW-1:0] r_f_cnt;
    logic [BCW-1:0] r_b_cnt;

    assign full   = (FCW+1)'(r_f_cnt) + (FCW+1)'(mq_count) >= (FCW+1)'(MQD);
    assign accept = push && !full;
    assign issue  = (mq_count != '0)
                 && ((BCW+1)'(r_b_cnt) + (BCW+1)'(oq_count) < (BCW+1)'(OQD));
    assign empty  = (oq_count == '0);
    assign oq_pop = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_cnt <= '0;
            r_b_cnt <= '0;
        end else begin
            r_f_cnt <= r_f_cnt + FCW'(accept) - FCW'(f_valid);
            r_b_cnt <= r_b_cnt + BCW'(issue) - BCW'(b_valid);
        end
    end

    epc_front #(.CW(CW), .MW(MW)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (accept),
        .i_first_pos_x   (i_first_pos_x),
        .i_first_pos_y   (i_first_pos_y),
        .i_first_vel_x   (i_first_vel_x),
        .i_first_vel_y   (i_first_vel_y),
        .i_first_mass    (i_first_mass),
        .i_first_radius  (i_first_radius),
        .i_second_pos_x  (i_second_pos_x),
        .i_second_pos_y  (i_second_pos_y),
        .i_second_vel_x  (i_second_vel_x),
        .i_second_vel_y  (i_second_vel_y),
        .i_second_mass   (i_second_mass),
        .i_second_radius (i_second_radius),
        .o_valid         (f_valid),
        .o_data          (f_data)
    );

    epc_fifo #(.W(EW), .DEPTH(MQD)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_data),
        .i_pop   (issue),
        .o_data  (mq_data),
        .o_count (mq_count)
    );

    epc_back #(.CW(CW), .MW(MW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_data  (mq_data),
        .o_valid (b_valid),
        .o_data  (b_data)
    );

    epc_fifo #(.W(OW), .DEPTH(OQD)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid),
        .i_data  (b_data),
        .i_pop   (oq_pop),
        .o_data  (oq_data),
        .o_count (oq_count)
    );

    assign {o_new_first_vel_x, o_new_first_vel_y, o_new_second_vel_x, o_new_second_vel_y,
            o_touching, o_approaching, o_degenerate} = oq_data;

    a_mid_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> (mq_count != FCW'(MQD)))
        else $error("middle queue overrun");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_valid |-> (oq_count != BCW'(OQD)))
        else $error("result queue overrun");

    a_front_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((FCW+1)'(r_f_cnt) + (FCW+1)'(mq_count)) <= (FCW+1)'(MQD))
        else $error("front credit exceeded");

    a_back_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((BCW+1)'(r_b_cnt) + (BCW+1)'(oq_count)) <= (BCW+1)'(OQD))
        else $error("back credit exceeded");

    a_degen_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_degenerate) |-> (o_touching && !o_approaching))
        else $error("coincident centres with inconsistent flags");

endmodule
